[hw/rtl/faz_pkg.sv]
// Shared constants for the flush-to-zero floating-point adder.
// No dependencies; imported by every module of the block.
package faz_pkg;
  localparam int DEF_WIDTH     = 32;
  localparam int DEF_EXP_WIDTH = 8;
  localparam int PORT_W        = 32;
  localparam int Q_DEPTH       = 4;
  localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);
endpackage

[hw/rtl/float_adder_flush_to_zero.sv]
// Top level of the flush-to-zero floating-point adder.
// Depends on faz_pkg, faz_front, faz_queue, faz_back.
//
// Adds two floating-point operands (WIDTH bits: sign, EXP_WIDTH exponent bits,
// mantissa) with round to nearest even. Exponent-zero operands count as zero,
// underflow flushes to signed zero. One transaction is taken per clock while
// busy is low, and each sum appears on out_sum_bits for exactly one cycle with
// out_valid high, in order. The receiver cannot stall: the back end drains the
// queue every cycle, so busy stays low and a new operand pair may enter every
// cycle. Each transaction passes the two front-end register stages (capture,
// classify; the alignment feeds the queue directly), one queue slot, three
// back-end stages (add, normalize, shift) and the output register.
// Bits above WIDTH on the inputs are ignored, on out_sum_bits they are zero.
module float_adder_flush_to_zero #(
  parameter int WIDTH     = faz_pkg::DEF_WIDTH,
  parameter int EXP_WIDTH = faz_pkg::DEF_EXP_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [faz_pkg::PORT_W-1:0]  in_operand_a,
  input  logic [faz_pkg::PORT_W-1:0]  in_operand_b,
  output logic                        out_valid,
  output logic [faz_pkg::PORT_W-1:0]  out_sum_bits
);
  import faz_pkg::*;

  localparam int MW    = WIDTH - EXP_WIDTH - 1;
  localparam int SW    = ((MW + 13) / 8) * 8;
  localparam int ENT_W = 1 + WIDTH + EXP_WIDTH + 2 * SW;

  logic               accept;
  logic [1:0]         inflight;
  logic               push;
  logic [ENT_W-1:0]   f_entry, q_entry;
  logic               q_empty;
  logic [Q_CNT_W-1:0] q_count;
  logic [Q_CNT_W-1:0] occ;

  // Count every transaction still ahead of the back end so the queue can
  // never overflow, even though the back end drains it every cycle.
  assign occ    = q_count + Q_CNT_W'(inflight[0]) + Q_CNT_W'(inflight[1]);
  assign busy   = (occ >= Q_CNT_W'(Q_DEPTH));
  assign accept = start && !busy;

  faz_front #(.WIDTH(WIDTH), .EXP_WIDTH(EXP_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .operand_a (in_operand_a),
    .operand_b (in_operand_b),
    .inflight  (inflight),
    .push      (push),
    .entry     (f_entry)
  );

  faz_queue #(.DATA_W(ENT_W), .DEPTH(Q_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (f_entry),
    .pop   (!q_empty),
    .rdata (q_entry),
    .empty (q_empty),
    .count (q_count)
  );

  faz_back #(.WIDTH(WIDTH), .EXP_WIDTH(EXP_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (!q_empty),
    .entry     (q_entry),
    .res_valid (out_valid),
    .res_bits  (out_sum_bits)
  );
endmodule

[hw/rtl/faz_front.sv]
// Front end: operand capture, special-case classification, exponent compare and alignment.
// Depends on faz_pkg.
module faz_front #(
  parameter int WIDTH     = 32,
  parameter int EXP_WIDTH = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [faz_pkg::PORT_W-1:0]  operand_a,
  input  logic [faz_pkg::PORT_W-1:0]  operand_b,
  output logic [1:0]                  inflight,
  output logic                        push,
  output logic [1+WIDTH+EXP_WIDTH+2*(((WIDTH-EXP_WIDTH-1+13)/8)*8)-1:0] entry
);
  import faz_pkg::*;

  localparam int MW   = WIDTH - EXP_WIDTH - 1;
  localparam int SW   = ((MW + 13) / 8) * 8;
  localparam int SIGW = MW + 4;
  localparam logic [EXP_WIDTH-1:0] EMAX = '1;

  // stage 1
  logic             v1_r;
  logic [WIDTH-1:0] ra_r, rb_r;

  // stage 2
  logic                 v2_r;
  logic                 spec2_r;
  logic [WIDTH-1:0]     specb2_r;
  logic [EXP_WIDTH-1:0] emax2_r;
  logic [EXP_WIDTH-1:0] diff2_r;
  logic [SIGW-1:0]      sig_big2_r, sig_sml2_r;
  logic                 sgn_big2_r, sgn_sml2_r;

  logic [EXP_WIDTH-1:0] ea, eb;
  logic                 sa, sb, ma, mb, nan_a, nan_b, inf_a, inf_b;
  logic                 spec;
  logic [WIDTH-1:0]     specb;
  logic                 a_big;
  logic [SIGW-1:0]      sig_a, sig_b;
  logic [SW-1:0]        big_ext, sml_ext, al_big, al_sml;
  logic [SIGW-1:0]      shr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
    if (accept) begin
      ra_r <= operand_a[WIDTH-1:0];
      rb_r <= operand_b[WIDTH-1:0];
    end
    if (v1_r) begin
      spec2_r    <= spec;
      specb2_r   <= specb;
      emax2_r    <= a_big ? ea : eb;
      diff2_r    <= a_big ? (ea - eb) : (eb - ea);
      sig_big2_r <= a_big ? sig_a : sig_b;
      sig_sml2_r <= a_big ? sig_b : sig_a;
      sgn_big2_r <= a_big ? sa : sb;
      sgn_sml2_r <= a_big ? sb : sa;
    end
  end

  always @(*) begin
    ea    = ra_r[WIDTH-2 -: EXP_WIDTH];
    eb    = rb_r[WIDTH-2 -: EXP_WIDTH];
    sa    = ra_r[WIDTH-1];
    sb    = rb_r[WIDTH-1];
    ma    = |ra_r[MW-1:0];
    mb    = |rb_r[MW-1:0];
    nan_a = (ea == EMAX) && ma;
    nan_b = (eb == EMAX) && mb;
    inf_a = (ea == EMAX) && !ma;
    inf_b = (eb == EMAX) && !mb;
    spec  = (ea == '0) || (eb == '0) || (ea == EMAX) || (eb == EMAX);
    if (nan_a || nan_b || (inf_a && inf_b && (sa != sb))) begin
      specb = {1'b0, EMAX, (MW)'(1)};
    end else if (inf_a) begin
      specb = {sa, EMAX, (MW)'(0)};
    end else if (inf_b) begin
      specb = {sb, EMAX, (MW)'(0)};
    end else if ((ea == '0) && (eb == '0)) begin
      specb = {(sa && sb), (WIDTH-1)'(0)};
    end else if (ea == '0) begin
      specb = rb_r;
    end else begin
      specb = ra_r;
    end
    a_big = ea >= eb;
    sig_a = {1'b1, ra_r[MW-1:0], 3'b000};
    sig_b = {1'b1, rb_r[MW-1:0], 3'b000};
  end

  // align the smaller significand, OR shifted-out bits into the sticky bit, then negate negative operands
  always @(*) begin
    shr     = sig_sml2_r >> diff2_r;
    big_ext = SW'(sig_big2_r);
    if (int'(diff2_r) >= SW) begin
      sml_ext = SW'(1);
    end else begin
      sml_ext = SW'(shr) | SW'((shr << diff2_r) != sig_sml2_r);
    end
    al_big = sgn_big2_r ? (SW'(0) - big_ext) : big_ext;
    al_sml = sgn_sml2_r ? (SW'(0) - sml_ext) : sml_ext;
  end

  assign push     = v2_r;
  assign entry    = {spec2_r, specb2_r, emax2_r, al_big, al_sml};
  assign inflight = {v2_r, v1_r};
endmodule

[hw/rtl/faz_queue.sv]
// Small FIFO decoupling the front end from the back end.
// Depends on faz_pkg.
module faz_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = faz_pkg::Q_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [DATA_W-1:0]            wdata,
  input  logic                         pop,
  output logic [DATA_W-1:0]            rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  import faz_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              do_pop;

  assign do_pop = pop && (cnt_r != '0);

  always @(*) begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;
endmodule

[hw/rtl/faz_back.sv]
// Back end: signed add, normalize, round to nearest even, pack.
// Depends on faz_pkg.
module faz_back #(
  parameter int WIDTH     = 32,
  parameter int EXP_WIDTH = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic [1+WIDTH+EXP_WIDTH+2*(((WIDTH-EXP_WIDTH-1+13)/8)*8)-1:0] entry,
  output logic                        res_valid,
  output logic [faz_pkg::PORT_W-1:0]  res_bits
);
  import faz_pkg::*;

  localparam int MW   = WIDTH - EXP_WIDTH - 1;
  localparam int SW   = ((MW + 13) / 8) * 8;
  localparam int SIGW = MW + 4;
  localparam int MAGW = MW + 5;
  localparam int EXW  = ((EXP_WIDTH > $clog2(MAGW)) ? EXP_WIDTH : $clog2(MAGW)) + 2;
  localparam logic [EXW-1:0] EMAXX = {(EXW-EXP_WIDTH)'(0), {EXP_WIDTH{1'b1}}};

  typedef struct packed {
    logic                 spec;
    logic [WIDTH-1:0]     specb;
    logic [EXP_WIDTH-1:0] emax;
    logic [SW-1:0]        al_a;
    logic [SW-1:0]        al_b;
  } ent_t;

  typedef struct packed {
    logic             spec;
    logic [WIDTH-1:0] specb;
    logic             sign;
    logic             zero;
  } ctl_t;

  function automatic logic [EXW-1:0] lead_zeros(input logic [SIGW-1:0] m);
    logic [EXW-1:0] n;
    n = '0;
    for (int i = 0; i < SIGW; i++) begin
      if (m[i]) begin
        n = EXW'(SIGW - 1 - i);
      end
    end
    return n;
  endfunction

  ent_t ent;
  assign ent = ent_t'(entry);

  // stage B1
  logic            v1_r;
  ctl_t            c1_r;
  logic [EXW-1:0]  e1_r;
  logic [MAGW-1:0] m1_r;
  // stage B2
  logic            v2_r;
  ctl_t            c2_r;
  logic [EXW-1:0]  e2_r, sh2_r;
  logic [SIGW-1:0] m2_r;
  // stage B3
  logic            v3_r;
  ctl_t            c3_r;
  logic [EXW-1:0]  e3_r;
  logic [SIGW-1:0] m3_r;
  // output
  logic                 out_v_r;
  logic [PORT_W-1:0]    out_r;

  logic [SW-1:0]   sum, mabs;
  logic            neg;
  logic [SIGW-1:0] m2;
  logic [EXW-1:0]  e2, lz;
  logic [MW:0]     kept;
  logic [MW+1:0]   kr;
  logic            inc;
  logic [EXW-1:0]  e4;
  logic [MW-1:0]   frac;
  logic [WIDTH-1:0] res;

  always @(*) begin
    sum  = ent.al_a + ent.al_b;
    neg  = sum[SW-1];
    mabs = neg ? (SW'(0) - sum) : sum;
  end

  // fold a carry-out back into range, sticky kept, and count leading zeros
  always @(*) begin
    if (m1_r[MAGW-1]) begin
      m2 = {m1_r[MAGW-1:2], m1_r[1] | m1_r[0]};
      e2 = e1_r + EXW'(1);
    end else begin
      m2 = m1_r[SIGW-1:0];
      e2 = e1_r;
    end
    lz = lead_zeros(m2);
  end

  always @(*) begin
    kept = m3_r[SIGW-1:3];
    inc  = m3_r[2] && (m3_r[1] || m3_r[0] || kept[0]);
    kr   = {1'b0, kept} + (MW+2)'(inc);
    if (kr[MW+1]) begin
      frac = kr[MW:1];
      e4   = e3_r + EXW'(1);
    end else begin
      frac = kr[MW-1:0];
      e4   = e3_r;
    end
    if (c3_r.spec) begin
      res = c3_r.specb;
    end else if (c3_r.zero) begin
      res = '0;
    end else if (e3_r == '0) begin
      res = {c3_r.sign, (WIDTH-1)'(0)};
    end else if ((e3_r >= EMAXX) || (e4 >= EMAXX)) begin
      res = {c3_r.sign, {EXP_WIDTH{1'b1}}, (MW)'(0)};
    end else begin
      res = {c3_r.sign, e4[EXP_WIDTH-1:0], frac};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      v1_r    <= take;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      out_v_r <= v3_r;
    end
    if (take) begin
      c1_r.spec  <= ent.spec;
      c1_r.specb <= ent.specb;
      c1_r.sign  <= neg;
      c1_r.zero  <= (sum == '0);
      e1_r       <= EXW'(ent.emax);
      m1_r       <= mabs[MAGW-1:0];
    end
    if (v1_r) begin
      c2_r  <= c1_r;
      e2_r  <= e2;
      m2_r  <= m2;
      sh2_r <= (lz < e2) ? lz : e2;
    end
    if (v2_r) begin
      c3_r <= c2_r;
      m3_r <= m2_r << sh2_r;
      e3_r <= e2_r - sh2_r;
    end
    if (v3_r) begin
      out_r <= PORT_W'(res);
    end
  end

  assign res_valid = out_v_r;
  assign res_bits  = out_r;
endmodule

[bench/sum_checker.sv]
// Checker for the flush-to-zero floating-point adder: predicts each sum and
// compares it with the block's output. Depends on faz_pkg for port widths.
module sum_checker #(
  parameter int WIDTH     = faz_pkg::DEF_WIDTH,
  parameter int EXP_WIDTH = faz_pkg::DEF_EXP_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [faz_pkg::PORT_W-1:0] in_operand_a,
  input  logic [faz_pkg::PORT_W-1:0] in_operand_b,
  input  logic                       out_valid,
  input  logic [faz_pkg::PORT_W-1:0] out_sum_bits,
  output int                         fail_count,
  output int                         pending_sums
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MW = WIDTH - EXP_WIDTH - 1;
  localparam int SW = ((MW + 6 + 7) / 8) * 8;
  localparam longint unsigned WORD_ONES = (64'd1 << WIDTH) - 1;
  localparam longint unsigned FRAC_ONES = (64'd1 << MW) - 1;
  localparam longint unsigned EXP_ALL = (64'd1 << EXP_WIDTH) - 1;
  localparam longint unsigned SIGN_BIT = 64'd1 << (WIDTH - 1);
  localparam longint unsigned ADDER_ONES = (64'd1 << SW) - 1;

  logic [faz_pkg::PORT_W-1:0] expected_sums[$];

  function automatic longint unsigned aligned_sig(longint unsigned raw, longint unsigned e_own,
                                                  longint unsigned e_other);
    longint unsigned sig, al, sh;
    sig = ((64'd1 << MW) | (raw & FRAC_ONES)) << 3;
    al = sig;
    if (e_own < e_other) begin
      sh = e_other - e_own;
      if (sh >= SW) al = 1;
      else begin
        al = sig >> sh;
        if ((sig & ((64'd1 << sh) - 1)) != 0) al |= 1;
      end
    end
    if ((raw & SIGN_BIT) != 0) al = (0 - al) & ADDER_ONES;
    return al & ADDER_ONES;
  endfunction

  function automatic longint unsigned predict_sum(longint unsigned a_in, longint unsigned b_in);
    longint unsigned ra, rb, ea, eb, sum, mag, sgn, kept;
    logic sa, sb, nan_a, nan_b, inf_a, inf_b, g, r, s;
    int e;
    ra = a_in & WORD_ONES;
    rb = b_in & WORD_ONES;
    ea = (ra >> MW) & EXP_ALL;
    eb = (rb >> MW) & EXP_ALL;
    sa = (ra & SIGN_BIT) != 0;
    sb = (rb & SIGN_BIT) != 0;
    if (ea == 0 || eb == 0 || ea == EXP_ALL || eb == EXP_ALL) begin
      nan_a = ea == EXP_ALL && (ra & FRAC_ONES) != 0;
      nan_b = eb == EXP_ALL && (rb & FRAC_ONES) != 0;
      inf_a = ea == EXP_ALL && (ra & FRAC_ONES) == 0;
      inf_b = eb == EXP_ALL && (rb & FRAC_ONES) == 0;
      if (nan_a || nan_b || (inf_a && inf_b && sa != sb)) return (EXP_ALL << MW) | 1;
      if (inf_a) return (sa ? SIGN_BIT : 0) | (EXP_ALL << MW);
      if (inf_b) return (sb ? SIGN_BIT : 0) | (EXP_ALL << MW);
      if (ea == 0 && eb == 0) return (sa && sb) ? SIGN_BIT : 0;
      return (ea == 0) ? rb : ra;
    end
    sum = (aligned_sig(ra, ea, eb) + aligned_sig(rb, eb, ea)) & ADDER_ONES;
    e = int'(ea >= eb ? ea : eb);
    sgn = sum[SW-1] ? SIGN_BIT : 0;
    mag = sum[SW-1] ? ((0 - sum) & ADDER_ONES) : sum;
    if (mag == 0) return 0;
    if (mag[MW+4]) begin
      mag = (mag >> 1) | (mag & 1);
      e++;
    end
    for (int i = 0; i < 32; i++)
      if (!mag[MW+3] && mag != 0 && e > 0) begin
        mag <<= 1;
        e--;
      end
    if (e <= 0) return sgn;
    if (e >= EXP_ALL) return sgn | (EXP_ALL << MW);
    kept = mag >> 3;
    g = mag[2];
    r = mag[1];
    s = mag[0];
    if (g && (r || s || kept[0])) kept++;
    if (kept >= (64'd1 << (MW + 1))) begin
      kept >>= 1;
      e++;
    end
    if (e >= EXP_ALL) return sgn | (EXP_ALL << MW);
    return sgn | (longint'(e) << MW) | (kept & FRAC_ONES);
  endfunction

  assign pending_sums = expected_sums.size();

  always @(posedge clk) begin
    logic [faz_pkg::PORT_W-1:0] want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (start && !busy)
        expected_sums.push_back(faz_pkg::PORT_W'(predict_sum(in_operand_a, in_operand_b)));
      if (out_valid) begin
        if (expected_sums.size() == 0) begin
          if (fail_count < 10) $display("unexpected sum %h", out_sum_bits);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_sums.pop_front();
          if (want !== out_sum_bits) begin
            if (fail_count < 10)
              $display("sum mismatch: expected %h got %h", want, out_sum_bits);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[bench/testbench.sv]
// Top of the adder bench: clock, reset, operand stimulus and verdict.
// Depends on faz_pkg, float_adder_flush_to_zero and sum_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIDTH = faz_pkg::DEF_WIDTH;
  localparam int EXP_WIDTH = faz_pkg::DEF_EXP_WIDTH;
  localparam int MW = WIDTH - EXP_WIDTH - 1;
  localparam int EXP_ALL = (1 << EXP_WIDTH) - 1;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy, out_valid;
  logic [faz_pkg::PORT_W-1:0] in_operand_a = '0, in_operand_b = '0, out_sum_bits;
  int fail_count, pending_sums;
  int idle_pct;

  always #6 clk = ~clk;

  float_adder_flush_to_zero #(.WIDTH(WIDTH), .EXP_WIDTH(EXP_WIDTH)) dut (.*);
  sum_checker #(.WIDTH(WIDTH), .EXP_WIDTH(EXP_WIDTH)) checker_i (.*);

  // Build an operand from its sign, exponent and mantissa fields.
  function automatic logic [31:0] pack_fp(int unsigned sgn, int unsigned ex, int unsigned man);
    return {sgn[0], ex[EXP_WIDTH-1:0], man[MW-1:0]};
  endfunction

  // Random operand: mostly normal numbers, many with exponents close together so
  // that cancellation and rounding get exercised, some specials and raw noise.
  function automatic logic [31:0] rand_operand(int unsigned near_exp);
    int unsigned pick, ex;
    pick = $urandom_range(99);
    if (pick < 8) return $urandom();
    if (pick < 14) return pack_fp($urandom_range(1), 0, $urandom());
    if (pick < 20) return pack_fp($urandom_range(1), EXP_ALL, ($urandom_range(1) ? $urandom() : 0));
    if (pick < 26) ex = $urandom_range(1, 30);
    else if (pick < 32) ex = $urandom_range(EXP_ALL - 30, EXP_ALL - 1);
    else if (pick < 70) begin
      ex = near_exp + $urandom_range(4) - 2;
      if (ex < 1) ex = 1;
      if (ex > EXP_ALL - 1) ex = EXP_ALL - 1;
    end else ex = $urandom_range(1, EXP_ALL - 1);
    return pack_fp($urandom_range(1), ex, $urandom());
  endfunction

  // One transaction: idle for random cycles, drive at the edge, hold until accepted.
  task automatic send_pair(logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_operand_a <= a;
    in_operand_b <= b;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_sums();
    start <= 1'b0;
    @(posedge clk);
    while (pending_sums != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] a, m;
    int unsigned ex;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 0;
    // Directed: zeros, infinities, NaN, cancellation, overflow, underflow, rounding.
    send_pair(pack_fp(0, 0, 0), pack_fp(0, 0, 0));
    send_pair(pack_fp(1, 0, 5), pack_fp(1, 0, 0));
    send_pair(pack_fp(1, 0, 0), pack_fp(0, 0, 0));
    send_pair(pack_fp(0, 0, 3), pack_fp(1, 100, 77));
    send_pair(pack_fp(0, 130, 99), pack_fp(0, 0, 1));
    send_pair(pack_fp(0, EXP_ALL, 1), pack_fp(0, 127, 0));
    send_pair(pack_fp(0, 127, 0), pack_fp(1, EXP_ALL, 12345));
    send_pair(pack_fp(0, EXP_ALL, 0), pack_fp(1, EXP_ALL, 0));
    send_pair(pack_fp(1, EXP_ALL, 0), pack_fp(1, EXP_ALL, 0));
    send_pair(pack_fp(1, EXP_ALL, 0), pack_fp(0, 12, 3));
    send_pair(pack_fp(0, 5, 3), pack_fp(0, EXP_ALL, 0));
    send_pair(pack_fp(0, 127, 777), pack_fp(1, 127, 777));
    send_pair(pack_fp(0, EXP_ALL - 1, '1), pack_fp(0, EXP_ALL - 1, '1));
    send_pair(pack_fp(0, EXP_ALL - 1, '1), pack_fp(0, EXP_ALL - 25, 0));
    send_pair(pack_fp(0, 1, 0), pack_fp(1, 1, 1));
    send_pair(pack_fp(1, 2, 0), pack_fp(0, 1, '1));
    send_pair(pack_fp(0, 127, 0), pack_fp(0, 103, 0));
    send_pair(pack_fp(0, 127, 1), pack_fp(0, 103, 0));
    send_pair(pack_fp(0, 200, 5), pack_fp(1, 1, 9));
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'h7FFF_FFFF, 32'h0000_0001);
    send_pair(pack_fp(0, 1, '1), pack_fp(0, 1, '1));
    // Sender waits until every sum has come back.
    drain_sums();
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 23 : (phase == 1) ? 55 : 0;
      for (int n = 0; n < 610; n++) begin
        ex = $urandom_range(1, EXP_ALL - 1);
        a = rand_operand(ex);
        if ($urandom_range(9) == 0) begin
          // Near or exact cancellation.
          m = a ^ 32'h8000_0000;
          if ($urandom_range(1)) m[1:0] = 2'($urandom());
          send_pair(a, m);
        end else
          send_pair(a, rand_operand(ex));
      end
    end
    drain_sums();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_sums == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

[files.f]
hw/rtl/faz_pkg.sv
hw/rtl/faz_front.sv
hw/rtl/faz_queue.sv
hw/rtl/faz_back.sv
hw/rtl/float_adder_flush_to_zero.sv
bench/sum_checker.sv
bench/testbench.sv
